FILE: src/bhcs_pkg.sv
// Package for the hall commutation and speed block: word types, event codes,
// widths and the hall-code gate table. Depends on nothing.
package bhcs_pkg;

	// Width of the tick and edge counters.
	localparam int CNT_W = 16;
	// Dividend edges*1000 needs ten more bits, divisor 6*pole_pairs*ticks seven more.
	localparam int NUM_W = CNT_W + 10;
	localparam int DEN_W = CNT_W + 7;
	localparam int DIVC_W = $clog2(NUM_W);
	localparam int SPD_W = 16;
	localparam int THR_W = 16;
	localparam int PP_W = 4;
	localparam int CFG_W = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [THR_W-1:0] THR_RESET = 16'd50;
	localparam logic [PP_W-1:0] PP_RESET = 4'd3;
	localparam logic [9:0] SCALE_MS = 10'd1000;

	// Event kinds.
	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_HALL = 2'd1;
	localparam logic [1:0] FUNC_KEY = 2'd2;
	localparam logic [1:0] FUNC_BREAK = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_UPDATE_TICKS = 1'b0;
	localparam logic CFG_POLE_PAIRS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic hall_a;
		logic hall_b;
		logic hall_c;
		logic key_down;
	} evt_t;

	typedef struct packed {
		logic [2:0] high_side;
		logic [2:0] low_side;
		logic [SPD_W-1:0] speed_rps;
		logic speed_updated;
	} res_t;

	// Gate pattern for hall code ABC: bits 2..0 high side, bits 5..3 low side.
	// The two impossible codes give zero.
	function automatic logic [5:0] hall_gates(input logic [2:0] code);
		logic [5:0] g;
		case (code)
			3'b101: g = {3'b010, 3'b001};
			3'b100: g = {3'b100, 3'b001};
			3'b110: g = {3'b100, 3'b010};
			3'b010: g = {3'b001, 3'b010};
			3'b011: g = {3'b001, 3'b100};
			3'b001: g = {3'b010, 3'b100};
			default: g = 6'b000000;
		endcase
		return g;
	endfunction

endpackage

FILE: src/bldc_hall_commutation_speed.sv
// Six-step hall commutation with speed estimation, top level.
// Depends on bhcs_pkg for word types, event codes, widths and the gate table.
//
// Usage: each input word on the evt channel is one event: a 1 ms tick, a hall
// edge, an enable-key change or a break fault. Every event yields exactly one
// result word on the res channel carrying the gate enables, the latest speed
// and a flag set when that event recomputed the speed.
// An ordinary event's result is registered when the word is accepted.
// A hall edge that meets the tick threshold starts a speed update: the MUL
// state forms the dividend and divisor with two small multipliers, then a
// restoring divider shifts in one quotient bit per cycle, NUM_W (26) bits in
// all, and the FIN state saturates and stores the speed and pushes its result
// word. No word is taken until the update is done.
// Ordinary events are taken at one word per cycle while evt_ready is high.
// The result register plus a one-word holding register let the block accept
// a new word while an earlier result still waits; when the receiver stalls
// and both are full, evt_ready drops until the receiver takes a word.
// Reset clears the drive enable, both counters, the gates (all off) and the
// speed, and loads the update threshold with 50 and pole pairs with 3.
// Configuration writes through cfg_we take effect at once; a register value of
// zero acts as one.
module bldc_hall_commutation_speed (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      evt_valid,
	output logic                      evt_ready,
	input  bhcs_pkg::evt_t            evt,
	output logic                      res_valid,
	input  logic                      res_ready,
	output bhcs_pkg::res_t            res,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bhcs_pkg::CFG_W-1:0] cfg_data
);

	// Configuration registers.
	logic [bhcs_pkg::THR_W-1:0] thr_q;
	logic [bhcs_pkg::PP_W-1:0] pp_q;

	// Block state.
	logic en_q;
	logic [bhcs_pkg::CNT_W-1:0] tick_q;
	logic [bhcs_pkg::CNT_W-1:0] edge_q;
	logic [5:0] gate_q;
	logic [bhcs_pkg::SPD_W-1:0] speed_q;

	// Sequencer and divider datapath.
	bhcs_pkg::state_t state_q, state_nx;
	logic [bhcs_pkg::NUM_W-1:0] num_q;
	logic [bhcs_pkg::DEN_W-1:0] den_q;
	logic [bhcs_pkg::DEN_W-1:0] rem_q;
	logic [bhcs_pkg::DIVC_W-1:0] div_cnt_q;

	// Result register and the holding register behind it.
	bhcs_pkg::res_t res_q, pend_word_q;
	logic res_valid_q, pend_q;

	// Control decoded from the state.
	logic idle_c, mul_en, div_en, fin_en;

	// Event decode.
	logic accept;
	logic [5:0] hall_g;
	logic hall_ok;
	logic [bhcs_pkg::THR_W-1:0] thr_eff;
	logic [bhcs_pkg::PP_W-1:0] pp_eff;
	logic start_div;
	logic [5:0] gate_nx;
	logic en_nx;
	logic [bhcs_pkg::CNT_W-1:0] tick_nx;
	logic [bhcs_pkg::CNT_W-1:0] edge_nx;

	// Divider step.
	logic [bhcs_pkg::DEN_W:0] trial;
	logic trial_ge;
	logic [bhcs_pkg::DEN_W:0] trial_diff;
	logic [6:0] pp6;
	logic [bhcs_pkg::SPD_W-1:0] speed_sat;

	// Result push.
	logic push;
	bhcs_pkg::res_t push_word;
	logic res_take;

	assign res_take = res_valid_q && res_ready;
	assign evt_ready = idle_c && !pend_q;
	assign accept = evt_valid && evt_ready;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign thr_eff = (thr_q == '0) ? bhcs_pkg::THR_W'(1) : thr_q;
	assign pp_eff = (pp_q == '0) ? bhcs_pkg::PP_W'(1) : pp_q;
	assign hall_g = bhcs_pkg::hall_gates({evt.hall_a, evt.hall_b, evt.hall_c});
	assign hall_ok = hall_g != 6'b000000;

	// Next values of the event state for an accepted word.
	always_comb begin
		gate_nx = gate_q;
		en_nx = en_q;
		tick_nx = tick_q;
		edge_nx = edge_q;
		start_div = 1'b0;
		case (evt.func)
			bhcs_pkg::FUNC_TICK: begin
				if (tick_q != bhcs_pkg::CNT_MAX) begin
					tick_nx = tick_q + bhcs_pkg::CNT_W'(1);
				end
			end
			bhcs_pkg::FUNC_HALL: begin
				if (en_q && hall_ok) begin
					gate_nx = hall_g;
					if (edge_q != bhcs_pkg::CNT_MAX) begin
						edge_nx = edge_q + bhcs_pkg::CNT_W'(1);
					end
					start_div = bhcs_pkg::CNT_W'(thr_eff) <= tick_q;
				end
			end
			bhcs_pkg::FUNC_KEY: begin
				if (evt.key_down) begin
					if (!en_q) begin
						en_nx = 1'b1;
						if (hall_ok) begin
							gate_nx = hall_g;
						end
					end
				end else begin
					en_nx = 1'b0;
					gate_nx = 6'b000000;
				end
			end
			bhcs_pkg::FUNC_BREAK: begin
				gate_nx = 6'b000000;
			end
			default: begin
				gate_nx = gate_q;
			end
		endcase
	end

	// Sequencer next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bhcs_pkg::ST_IDLE: begin
				if (accept && start_div) begin
					state_nx = bhcs_pkg::ST_MUL;
				end
			end
			bhcs_pkg::ST_MUL: begin
				state_nx = bhcs_pkg::ST_DIV;
			end
			bhcs_pkg::ST_DIV: begin
				if (div_cnt_q == bhcs_pkg::DIVC_W'(bhcs_pkg::NUM_W - 1)) begin
					state_nx = bhcs_pkg::ST_FIN;
				end
			end
			bhcs_pkg::ST_FIN: begin
				state_nx = bhcs_pkg::ST_IDLE;
			end
			default: begin
				state_nx = bhcs_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		idle_c = 1'b0;
		mul_en = 1'b0;
		div_en = 1'b0;
		fin_en = 1'b0;
		case (state_q)
			bhcs_pkg::ST_IDLE: idle_c = 1'b1;
			bhcs_pkg::ST_MUL: mul_en = 1'b1;
			bhcs_pkg::ST_DIV: div_en = 1'b1;
			bhcs_pkg::ST_FIN: fin_en = 1'b1;
			default: idle_c = 1'b0;
		endcase
	end

	// One restoring division step: shift in the next dividend bit and subtract.
	assign trial = {rem_q, num_q[bhcs_pkg::NUM_W-1]};
	assign trial_ge = trial >= {1'b0, den_q};
	assign trial_diff = trial - {1'b0, den_q};
	assign pp6 = ({3'b000, pp_eff} << 2) + ({3'b000, pp_eff} << 1);
	assign speed_sat = (|num_q[bhcs_pkg::NUM_W-1:bhcs_pkg::SPD_W]) ? '1
		: num_q[bhcs_pkg::SPD_W-1:0];

	// Result for this cycle, if any.
	always_comb begin
		push = 1'b0;
		push_word.high_side = gate_nx[2:0];
		push_word.low_side = gate_nx[5:3];
		push_word.speed_rps = speed_q;
		push_word.speed_updated = 1'b0;
		if (fin_en) begin
			push = 1'b1;
			push_word.high_side = gate_q[2:0];
			push_word.low_side = gate_q[5:3];
			push_word.speed_rps = speed_sat;
			push_word.speed_updated = 1'b1;
		end else if (accept && !start_div) begin
			push = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bhcs_pkg::THR_RESET;
			pp_q <= bhcs_pkg::PP_RESET;
		end else if (cfg_we) begin
			if (cfg_index == bhcs_pkg::CFG_UPDATE_TICKS) begin
				thr_q <= cfg_data[bhcs_pkg::THR_W-1:0];
			end else begin
				pp_q <= cfg_data[bhcs_pkg::PP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhcs_pkg::ST_IDLE;
			en_q <= 1'b0;
			tick_q <= '0;
			edge_q <= '0;
			gate_q <= '0;
			speed_q <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				en_q <= en_nx;
				tick_q <= tick_nx;
				edge_q <= edge_nx;
				gate_q <= gate_nx;
			end
			if (mul_en) begin
				div_cnt_q <= '0;
			end else if (div_en) begin
				div_cnt_q <= div_cnt_q + bhcs_pkg::DIVC_W'(1);
			end
			if (fin_en) begin
				speed_q <= speed_sat;
				tick_q <= '0;
				edge_q <= '0;
			end
		end
	end

	// Divider datapath: operands are formed once, then one bit per cycle.
	always_ff @(posedge clk) begin
		if (mul_en) begin
			num_q <= bhcs_pkg::NUM_W'(edge_q) * bhcs_pkg::NUM_W'(bhcs_pkg::SCALE_MS);
			den_q <= bhcs_pkg::DEN_W'(pp6) * bhcs_pkg::DEN_W'(tick_q);
			rem_q <= '0;
		end else if (div_en) begin
			num_q <= {num_q[bhcs_pkg::NUM_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_diff[bhcs_pkg::DEN_W-1:0] : trial[bhcs_pkg::DEN_W-1:0];
		end
	end

	// Result register with one holding register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (push) begin
			if ((!res_valid_q || res_take) && !pend_q) begin
				res_valid_q <= 1'b1;
			end else begin
				pend_q <= 1'b1;
			end
		end else if (res_take) begin
			if (pend_q) begin
				pend_q <= 1'b0;
			end else begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if ((!res_valid_q || res_take) && !pend_q) begin
				res_q <= push_word;
			end else begin
				pend_word_q <= push_word;
			end
		end else if (res_take && pend_q) begin
			res_q <= pend_word_q;
		end
	end

	// The block never takes a word while a speed update is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != bhcs_pkg::ST_IDLE) |-> !evt_ready)
		else $error("word accepted during a speed update");

	// A held result always sits behind a valid output word.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> res_valid_q)
		else $error("holding register full while output register empty");

	// Driven gates are one high side and one low side on different phases.
	assert property (@(posedge clk) disable iff (!arst_n)
		(gate_q != 6'b000000) |-> ($onehot(gate_q[2:0]) && $onehot(gate_q[5:3])
		&& ((gate_q[2:0] & gate_q[5:3]) == 3'b000)))
		else $error("illegal gate pattern");

	// Finishing a speed update clears both counters.
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_en |=> (tick_q == '0) && (edge_q == '0))
		else $error("counters not cleared after a speed update");

endmodule

FILE: tb/bldc_hall_commutation_speed_tb.sv
// Self-checking testbench for the hall commutation and speed block.
// Depends on bhcs_pkg (word types, event codes, widths) and the block's RTL.
module bldc_hall_commutation_speed_tb;

	// Phase bits used to build the expected gate pattern: bit0 U, bit1 V, bit2 W.
	localparam logic [2:0] PH_U = 3'b001;
	localparam logic [2:0] PH_V = 3'b010;
	localparam logic [2:0] PH_W = 3'b100;

	// A receiver hold-off long enough to fill both result stages and stall the input.
	localparam int HOLD_CYCLES = 300;
	// Drain margin at the end, long enough to cover a speed update.
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_WORDS = 185;
	localparam int NUM_PHASES = 7;

	// The directed plan holds two kinds of rows: an event word, possibly
	// repeated, or a write of both registers while the block is idle.
	typedef enum logic {
		ROW_EVT,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		bhcs_pkg::evt_t w;
		int reps;
		bit typed;
		bhcs_pkg::res_t want;
		logic [bhcs_pkg::CFG_W-1:0] thr;
		logic [bhcs_pkg::CFG_W-1:0] ppd;
	} row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_ready;
	bhcs_pkg::evt_t evt = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	bhcs_pkg::res_t res;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [bhcs_pkg::CFG_W-1:0] cfg_data = '0;

	bldc_hall_commutation_speed DUT (
		.clk(clk),
		.arst_n(arst_n),
		.evt_valid(evt_valid),
		.evt_ready(evt_ready),
		.evt(evt),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Our own copy of the block's state and registers, at their reset values.
	logic drive_on = 1'b0;
	logic [bhcs_pkg::CNT_W-1:0] tick_cnt = '0;
	logic [bhcs_pkg::CNT_W-1:0] edge_cnt = '0;
	logic [5:0] gates = '0;
	logic [bhcs_pkg::SPD_W-1:0] speed_est = '0;
	logic [bhcs_pkg::THR_W-1:0] cfg_thr = bhcs_pkg::THR_RESET;
	logic [bhcs_pkg::PP_W-1:0] cfg_pp = bhcs_pkg::PP_RESET;

	// Result words predicted for accepted events, oldest first.
	bhcs_pkg::res_t commutation_q[$];

	// Idle percentages of the two sides, changed between phases.
	int snd_idle = 26;
	int rcv_idle = 54;
	// Gap the sender waits before its next word, drawn when a word is accepted.
	int gap_next = 0;
	// Set once evt_valid has been given a low value for the coming cycle.
	bit vld_low = 1'b1;
	// Request from the stimulus for a long receiver hold-off, and its countdown.
	bit hold_req = 1'b0;
	int hold_left = 0;

	// Forward rotation of hall codes; random items step through it either way.
	logic [2:0] hall_seq [6] = '{3'b101, 3'b100, 3'b110, 3'b010, 3'b011, 3'b001};
	int rot = 0;
	int spin_dir = 1;

	int err_cnt = 0;
	int words_in = 0;
	int words_out = 0;
	int upd_seen = 0;
	int cfg_writes = 0;
	bhcs_pkg::res_t seen_want;

	// Clock: period of 10 time units.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gate pattern for hall code ABC, low side in bits 5..3 and high side in
	// bits 2..0. The two codes a healthy sensor set never shows give all off.
	function automatic logic [5:0] phase_pattern(input logic [2:0] code);
		logic [2:0] hi;
		logic [2:0] lo;
		hi = '0;
		lo = '0;
		case (code)
			3'b101: begin hi = PH_U; lo = PH_V; end
			3'b100: begin hi = PH_U; lo = PH_W; end
			3'b110: begin hi = PH_V; lo = PH_W; end
			3'b010: begin hi = PH_V; lo = PH_U; end
			3'b011: begin hi = PH_W; lo = PH_U; end
			3'b001: begin hi = PH_W; lo = PH_V; end
			default: begin hi = '0; lo = '0; end
		endcase
		return {lo, hi};
	endfunction

	// Advances our copy of the block by one event and returns the result word
	// that the event must produce.
	function automatic bhcs_pkg::res_t predict_commutation(input bhcs_pkg::evt_t w);
		bhcs_pkg::res_t r;
		logic [5:0] pat;
		logic [bhcs_pkg::THR_W-1:0] thr_eff;
		logic [bhcs_pkg::PP_W-1:0] pp_eff;
		logic [63:0] den;
		logic [63:0] quo;
		pat = phase_pattern({w.hall_a, w.hall_b, w.hall_c});
		r.speed_updated = 1'b0;
		case (w.func)
			bhcs_pkg::FUNC_TICK: begin
				if (tick_cnt != bhcs_pkg::CNT_MAX)
					tick_cnt = tick_cnt + bhcs_pkg::CNT_W'(1);
			end
			bhcs_pkg::FUNC_HALL: begin
				// Edges count only while driving and only for a real hall code.
				if (drive_on && pat != 6'd0) begin
					gates = pat;
					if (edge_cnt != bhcs_pkg::CNT_MAX)
						edge_cnt = edge_cnt + bhcs_pkg::CNT_W'(1);
					// A zero register behaves as one.
					thr_eff = (cfg_thr == '0) ? bhcs_pkg::THR_W'(1) : cfg_thr;
					if (tick_cnt >= thr_eff) begin
						pp_eff = (cfg_pp == '0) ? bhcs_pkg::PP_W'(1) : cfg_pp;
						den = 64'd6 * pp_eff * tick_cnt;
						quo = (edge_cnt * 64'd1000) / den;
						speed_est = (quo > 64'hFFFF) ? '1 : quo[bhcs_pkg::SPD_W-1:0];
						tick_cnt = '0;
						edge_cnt = '0;
						r.speed_updated = 1'b1;
					end
				end
			end
			bhcs_pkg::FUNC_KEY: begin
				if (w.key_down) begin
					// Enabling sets the gates from the present code but is no edge.
					if (!drive_on) begin
						drive_on = 1'b1;
						if (pat != 6'd0)
							gates = pat;
					end
				end else begin
					drive_on = 1'b0;
					gates = '0;
				end
			end
			default: begin
				// A break fault only switches the gates off.
				gates = '0;
			end
		endcase
		r.high_side = gates[2:0];
		r.low_side = gates[5:3];
		r.speed_rps = speed_est;
		return r;
	endfunction

	// Draws one random event. While the drive is off, most items re-enable it;
	// hall edges mostly follow the six-step rotation in either direction, with
	// some random codes (the two invalid ones among them) mixed in.
	function automatic bhcs_pkg::evt_t next_event();
		bhcs_pkg::evt_t w;
		int r;
		logic [2:0] code;
		r = $urandom_range(99);
		w.key_down = 1'($urandom_range(1));
		code = 3'($urandom_range(7));
		if (!drive_on && r < 60) begin
			w.func = bhcs_pkg::FUNC_KEY;
			w.key_down = 1'b1;
			code = hall_seq[$urandom_range(5)];
		end else if (r < 4) begin
			w.func = bhcs_pkg::FUNC_KEY;
			w.key_down = 1'b0;
		end else if (r < 8) begin
			w.func = bhcs_pkg::FUNC_KEY;
		end else if (r < 11) begin
			w.func = bhcs_pkg::FUNC_BREAK;
		end else if (r < 45) begin
			w.func = bhcs_pkg::FUNC_TICK;
		end else begin
			w.func = bhcs_pkg::FUNC_HALL;
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(49) == 0)
					spin_dir = -spin_dir;
				rot = (rot + spin_dir + 6) % 6;
				code = hall_seq[rot];
			end
		end
		{w.hall_a, w.hall_b, w.hall_c} = code;
		return w;
	endfunction

	function automatic row_t ev(input logic [1:0] f, input logic [2:0] h, input logic k,
			input int reps);
		row_t r;
		r.kind = ROW_EVT;
		r.w.func = f;
		{r.w.hall_a, r.w.hall_b, r.w.hall_c} = h;
		r.w.key_down = k;
		r.reps = reps;
		r.typed = 1'b0;
		r.want = '0;
		r.thr = '0;
		r.ppd = '0;
		return r;
	endfunction

	// An event row whose result is typed in: the speed is still zero there.
	function automatic row_t evk(input logic [1:0] f, input logic [2:0] h, input logic k,
			input logic [2:0] hi, input logic [2:0] lo);
		row_t r;
		r = ev(f, h, k, 1);
		r.typed = 1'b1;
		r.want = '{high_side: hi, low_side: lo, speed_rps: '0, speed_updated: 1'b0};
		return r;
	endfunction

	function automatic row_t cf(input logic [bhcs_pkg::CFG_W-1:0] thr,
			input logic [bhcs_pkg::CFG_W-1:0] ppd);
		row_t r;
		r = ev(bhcs_pkg::FUNC_TICK, 3'b000, 1'b0, 0);
		r.kind = ROW_CFG;
		r.thr = thr;
		r.ppd = ppd;
		return r;
	endfunction

	task automatic note_failure(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// Offers one event word and waits for its acceptance. The expectation is
	// queued at the accepting edge, before its result can appear.
	// The gap before the following word is drawn here, so that evt_valid is
	// either lowered at the accepting edge or kept high for the next word.
	task automatic send_word(input bhcs_pkg::evt_t w, input bit typed,
			input bhcs_pkg::res_t typed_res);
		bhcs_pkg::res_t want;
		repeat (gap_next) @(posedge clk);
		evt <= w;
		evt_valid <= 1'b1;
		vld_low = 1'b0;
		do @(posedge clk); while (!evt_ready);
		want = predict_commutation(w);
		if (typed)
			want = typed_res;
		commutation_q.push_back(want);
		words_in++;
		gap_next = 0;
		while (gap_next < 40 && $urandom_range(99) < snd_idle)
			gap_next++;
		if (gap_next > 0) begin
			evt_valid <= 1'b0;
			vld_low = 1'b1;
		end
	endtask

	// Called in the step of the last acceptance before the sender waits.
	task automatic hold_sender();
		if (!vld_low) begin
			evt_valid <= 1'b0;
			vld_low = 1'b1;
		end
	endtask

	task automatic wait_drained();
		while (commutation_q.size() != 0)
			@(posedge clk);
	endtask

	// Writes both registers in back-to-back cycles; the block is idle here.
	task automatic write_regs(input logic [bhcs_pkg::CFG_W-1:0] thr,
			input logic [bhcs_pkg::CFG_W-1:0] ppd);
		cfg_we <= 1'b1;
		cfg_index <= bhcs_pkg::CFG_UPDATE_TICKS;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= bhcs_pkg::CFG_POLE_PAIRS;
		cfg_data <= ppd;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_thr = thr[bhcs_pkg::THR_W-1:0];
		cfg_pp = ppd[bhcs_pkg::PP_W-1:0];
		cfg_writes += 2;
	endtask

	// Receiver and checker. Outputs are sampled right after the edge, before
	// any of this edge's updates land, so a word is taken exactly when valid
	// and ready were both high at the edge. Ready is then redrawn for the next
	// cycle, or held low while a long hold-off runs.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			words_out++;
			if (res.speed_updated)
				upd_seen++;
			if (commutation_q.size() == 0) begin
				note_failure($sformatf("result word with none expected: hi=%b lo=%b spd=%0d upd=%b",
					res.high_side, res.low_side, res.speed_rps, res.speed_updated));
			end else begin
				seen_want = commutation_q.pop_front();
				if (res.high_side !== seen_want.high_side || res.low_side !== seen_want.low_side ||
						res.speed_rps !== seen_want.speed_rps ||
						res.speed_updated !== seen_want.speed_updated)
					note_failure($sformatf(
						"word %0d: expected hi=%b lo=%b spd=%0d upd=%b, got hi=%b lo=%b spd=%0d upd=%b",
						words_out, seen_want.high_side, seen_want.low_side, seen_want.speed_rps,
						seen_want.speed_updated, res.high_side, res.low_side, res.speed_rps,
						res.speed_updated));
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// Hard limit on the run, several times the slowest legal run.
	initial begin
		#40000000;
		$display("Timeout with %0d result words still outstanding", commutation_q.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		row_t plan[$];
		logic [bhcs_pkg::CFG_W-1:0] thr_p;
		logic [bhcs_pkg::PP_W-1:0] pp_p;
		logic [11:0] junk;

		// Directed plan. The first rows run on the reset register values and
		// have their results typed in; later rows go through the predictor.
		// Reset state, then a hall edge while disabled and a disable while off.
		plan.push_back(evk(bhcs_pkg::FUNC_TICK, 3'b000, 1'b0, 3'b000, 3'b000));
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b101, 1'b0, 3'b000, 3'b000));
		plan.push_back(evk(bhcs_pkg::FUNC_KEY, 3'b101, 1'b0, 3'b000, 3'b000));
		// Enabling on an invalid code leaves the gates off; invalid edges do nothing.
		plan.push_back(evk(bhcs_pkg::FUNC_KEY, 3'b000, 1'b1, 3'b000, 3'b000));
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b111, 1'b1, 3'b000, 3'b000));
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b000, 1'b0, 3'b000, 3'b000));
		// All six valid codes in rotation.
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b101, 1'b0, PH_U, PH_V));
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b100, 1'b1, PH_U, PH_W));
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b110, 1'b0, PH_V, PH_W));
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b010, 1'b1, PH_V, PH_U));
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b011, 1'b0, PH_W, PH_U));
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b001, 1'b1, PH_W, PH_V));
		// Break switches off but keeps the drive enabled for the next edge.
		plan.push_back(evk(bhcs_pkg::FUNC_BREAK, 3'b111, 1'b1, 3'b000, 3'b000));
		plan.push_back(evk(bhcs_pkg::FUNC_HALL, 3'b101, 1'b0, PH_U, PH_V));
		// Enable while already enabled changes nothing; disable, then re-enable.
		plan.push_back(evk(bhcs_pkg::FUNC_KEY, 3'b011, 1'b1, PH_U, PH_V));
		plan.push_back(evk(bhcs_pkg::FUNC_KEY, 3'b011, 1'b0, 3'b000, 3'b000));
		plan.push_back(evk(bhcs_pkg::FUNC_KEY, 3'b110, 1'b1, PH_V, PH_W));
		// Smallest registers: one tick then an edge gives a speed update.
		plan.push_back(cf(16'd1, 16'd1));
		plan.push_back(ev(bhcs_pkg::FUNC_TICK, 3'b000, 1'b0, 1));
		plan.push_back(ev(bhcs_pkg::FUNC_HALL, 3'b100, 1'b0, 1));
		// Many edges without ticks, then one tick: the speed saturates.
		plan.push_back(ev(bhcs_pkg::FUNC_HALL, 3'b110, 1'b1, 400));
		plan.push_back(ev(bhcs_pkg::FUNC_TICK, 3'b111, 1'b1, 1));
		plan.push_back(ev(bhcs_pkg::FUNC_HALL, 3'b010, 1'b0, 1));
		// Zero registers act as one; the upper data bits of pole pairs are unused.
		plan.push_back(cf(16'd0, 16'hFFF0));
		plan.push_back(ev(bhcs_pkg::FUNC_TICK, 3'b000, 1'b0, 1));
		plan.push_back(ev(bhcs_pkg::FUNC_HALL, 3'b011, 1'b1, 1));
		// Largest registers: the tick count stays far below the threshold, so
		// edges commutate without a speed update.
		plan.push_back(cf(16'hFFFF, 16'h000F));
		plan.push_back(ev(bhcs_pkg::FUNC_HALL, 3'b001, 1'b0, 20));
		plan.push_back(ev(bhcs_pkg::FUNC_TICK, 3'b010, 1'b1, 20));
		plan.push_back(ev(bhcs_pkg::FUNC_HALL, 3'b101, 1'b1, 1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				hold_sender();
				wait_drained();
				write_regs(plan[i].thr, plan[i].ppd);
			end else begin
				repeat (plan[i].reps)
					send_word(plan[i].w, plan[i].typed, plan[i].want);
			end
		end

		// Random phases, each on its own register setting. The first three let
		// the sender idle less than the receiver, the next two the reverse, and
		// the last two run with no idling at all.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin thr_p = 16'd3; pp_p = 4'd1; end
				1: begin
					thr_p = bhcs_pkg::CFG_W'($urandom_range(12, 1));
					pp_p = bhcs_pkg::PP_W'($urandom_range(15, 1));
				end
				2: begin thr_p = 16'd0; pp_p = 4'd0; end
				3: begin thr_p = 16'd1; pp_p = 4'd15; end
				4: begin
					thr_p = bhcs_pkg::CFG_W'($urandom_range(30, 1));
					pp_p = bhcs_pkg::PP_W'($urandom_range(15, 1));
				end
				5: begin thr_p = 16'hFFFF; pp_p = 4'd1; end
				default: begin thr_p = 16'd2; pp_p = bhcs_pkg::PP_W'($urandom_range(15, 1)); end
			endcase
			if (p < 3) begin
				snd_idle = 26;
				rcv_idle = 54;
			end else if (p < 5) begin
				snd_idle = 54;
				rcv_idle = 26;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			junk = 12'($urandom);
			hold_sender();
			wait_drained();
			write_regs(thr_p, {junk, pp_p});
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// A long receiver stall while words keep coming fills the block.
				if (p == 0 && i == 20)
					hold_req = 1'b1;
				// Once, the sender stops until every outstanding result is back.
				if (p == 1 && i == 120) begin
					hold_sender();
					wait_drained();
				end
				send_word(next_event(), 1'b0, '0);
			end
		end

		hold_sender();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (commutation_q.size() != 0)
			note_failure($sformatf("%0d result words never arrived", commutation_q.size()));

		$display("Sent %0d event words and checked %0d result words, %0d of them speed updates.",
			words_in, words_out, upd_seen);
		$display("Register writes: %0d over %0d settings; mismatches counted: %0d.",
			cfg_writes, cfg_writes / 2, err_cnt);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
